/* sv/ascr_pkg.sv */
// Shared types, codes and helpers of the alpha-weighted scatter raster.
`timescale 1ns / 1ps
package ascr_pkg;

	localparam int MAX_ADDR_BITS = 24;
	localparam int SIDE_BITS = 13;
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_SPARE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_ACCUM = 2'd0,
		ST_DROP  = 2'd1,
		ST_READ  = 2'd2,
		ST_CLEAR = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_WIDTH   = 3'd0,
		REG_HEIGHT  = 3'd1,
		REG_XORIGIN = 3'd2,
		REG_XSCALE  = 3'd3,
		REG_YORIGIN = 3'd4,
		REG_YSCALE  = 3'd5
	} reg_index_t;

	typedef enum logic [1:0] {
		CMD_ADD,
		CMD_DROP,
		CMD_READ,
		CMD_CLEAR
	} cmd_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_DIFF,
		F_MUL,
		F_SUM,
		F_BIN,
		F_ADDR,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_READ,
		B_WRITE
	} back_state_t;

	typedef struct packed {
		cmd_t                     kind;
		logic [MAX_ADDR_BITS-1:0] addr;
		logic [16:0]              red;
		logic [16:0]              green;
		logic [16:0]              blue;
		logic [16:0]              alpha;
	} entry_t;

	typedef struct packed {
		logic [31:0] red;
		logic [31:0] green;
		logic [31:0] blue;
		logic [31:0] weight;
		logic [16:0] trans;
	} pixel_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] addr;
		pixel_t      px;
	} result_t;

	localparam pixel_t PIXEL_RESET = '{32'd0, 32'd0, 32'd0, 32'd0, ONE_Q16};

	function automatic logic [16:0] clamp_one(logic [16:0] v);
		return (v > ONE_Q16) ? ONE_Q16 : v;
	endfunction

	function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

/* sv/ascr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ascr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH_BITS = 4
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [DEPTH_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic [DEPTH_BITS-1:0] raddr,
	output logic [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem [2**DEPTH_BITS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/ascr_front.sv */
// Front end: configuration registers, request capture and pixel mapping.
`timescale 1ns / 1ps
module ascr_front #(
	parameter int COLUMN_BITS = 8,
	parameter int ROW_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [1:0]          op,
	input  logic signed [31:0]  x_coord,
	input  logic signed [31:0]  y_coord,
	input  logic [16:0]         red,
	input  logic [16:0]         green,
	input  logic [16:0]         blue,
	input  logic [16:0]         alpha,
	input  logic [15:0]         target_pixel,
	input  logic                cfg_write,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                full,
	output logic                push,
	output ascr_pkg::entry_t    push_entry,
	output logic                busy
);
	import ascr_pkg::*;

	localparam int AW = COLUMN_BITS + ROW_BITS;
	localparam logic [MAX_ADDR_BITS-1:0] ADDR_MASK = (MAX_ADDR_BITS'(1) << AW) - 1'b1;
	localparam logic [SIDE_BITS-1:0] W_LIM = SIDE_BITS'(1) << COLUMN_BITS;
	localparam logic [SIDE_BITS-1:0] H_LIM = SIDE_BITS'(1) << ROW_BITS;

	front_state_t state_q, state_d;

	logic [8:0]         width_q, height_q;
	logic signed [31:0] xorg_q, xscl_q, yorg_q, yscl_q;

	logic signed [31:0] x_q, y_q;
	logic signed [32:0] dx_q, dy_q;
	logic signed [49:0] pxl_q, pyl_q;
	logic signed [48:0] pxh_q, pyh_q;
	logic signed [64:0] px_q, py_q;
	logic signed [32:0] col_q, row_q;
	entry_t             entry_q;

	logic [SIDE_BITS-1:0]    eff_w, eff_h;
	logic                    drop;
	logic [AW:0]             addr_sum;
	logic [MAX_ADDR_BITS-1:0] tgt_addr;

	assign eff_w = (SIDE_BITS'(width_q) < W_LIM) ? SIDE_BITS'(width_q) : W_LIM;
	assign eff_h = (SIDE_BITS'(height_q) < H_LIM) ? SIDE_BITS'(height_q) : H_LIM;

	assign drop = col_q[32] || row_q[32] || (col_q >= $signed({20'd0, eff_w}))
		|| (row_q >= $signed({20'd0, eff_h}));
	assign addr_sum = (AW + 1)'(col_q[COLUMN_BITS-1:0] * eff_h[ROW_BITS:0])
		+ (AW + 1)'(row_q[ROW_BITS-1:0]);
	assign tgt_addr = MAX_ADDR_BITS'(target_pixel) & ADDR_MASK;

	assign busy = (state_q != F_IDLE);
	assign push_entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			width_q  <= 9'd256;
			height_q <= 9'd256;
			xorg_q   <= 32'sd0;
			xscl_q   <= 32'sd65536;
			yorg_q   <= 32'sd0;
			yscl_q   <= 32'sd65536;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				unique case (cfg_index)
					REG_WIDTH:   width_q  <= cfg_data[8:0];
					REG_HEIGHT:  height_q <= cfg_data[8:0];
					REG_XORIGIN: xorg_q   <= cfg_data;
					REG_XSCALE:  xscl_q   <= cfg_data;
					REG_YORIGIN: yorg_q   <= cfg_data;
					REG_YSCALE:  yscl_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// The 33 x 32 product is built from two 33 x 16 halves of the scale.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= x_coord;
			y_q <= y_coord;
			entry_q.red   <= clamp_one(red);
			entry_q.green <= clamp_one(green);
			entry_q.blue  <= clamp_one(blue);
			entry_q.alpha <= clamp_one(alpha);
			entry_q.addr  <= tgt_addr;
			unique case (op_t'(op))
				OP_ADD:   entry_q.kind <= CMD_ADD;
				OP_CLEAR: entry_q.kind <= CMD_CLEAR;
				default:  entry_q.kind <= CMD_READ;
			endcase
		end
		if (state_q == F_DIFF) begin
			dx_q <= 33'(x_q) - 33'(xorg_q);
			dy_q <= 33'(y_q) - 33'(yorg_q);
		end
		if (state_q == F_MUL) begin
			pxl_q <= dx_q * $signed({1'b0, xscl_q[15:0]});
			pxh_q <= dx_q * $signed(xscl_q[31:16]);
			pyl_q <= dy_q * $signed({1'b0, yscl_q[15:0]});
			pyh_q <= dy_q * $signed(yscl_q[31:16]);
		end
		if (state_q == F_SUM) begin
			px_q <= (65'(pxh_q) <<< 16) + 65'(pxl_q);
			py_q <= (65'(pyh_q) <<< 16) + 65'(pyl_q);
		end
		if (state_q == F_BIN) begin
			// Floor shift, then one up for a negative product with a fraction.
			col_q <= $signed(px_q[64:32]) + $signed({32'd0, px_q[64] && (px_q[31:0] != 32'd0)});
			row_q <= $signed(py_q[64:32]) + $signed({32'd0, py_q[64] && (py_q[31:0] != 32'd0)});
		end
		if (state_q == F_ADDR) begin
			entry_q.kind <= drop ? CMD_DROP : CMD_ADD;
			entry_q.addr <= MAX_ADDR_BITS'(addr_sum[AW-1:0]);
		end
	end

	always_comb begin
		state_d = state_q;
		push = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_d = (op_t'(op) == OP_ADD) ? F_DIFF : F_PUSH;
				end
			end
			F_DIFF: state_d = F_MUL;
			F_MUL:  state_d = F_SUM;
			F_SUM:  state_d = F_BIN;
			F_BIN:  state_d = F_ADDR;
			F_ADDR: state_d = F_PUSH;
			F_PUSH: begin
				if (!full) begin
					push = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end
endmodule

/* sv/ascr_queue.sv */
// Two-entry request queue between the front end and the back end.
`timescale 1ns / 1ps
module ascr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ascr_pkg::entry_t push_entry,
	input  logic             pop,
	output ascr_pkg::entry_t head,
	output logic             empty,
	output logic             full
);
	import ascr_pkg::*;

	entry_t     slot_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] count_q;

	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);
	assign head  = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_entry;
		end
	end
endmodule

/* sv/ascr_back.sv */
// Back end: clearing pass and read-modify-write of the pixel stores.
`timescale 1ns / 1ps
module ascr_back #(
	parameter int COLUMN_BITS = 8,
	parameter int ROW_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ascr_pkg::entry_t  head,
	input  logic              empty,
	output logic              pop,
	output logic              busy,
	output logic              res_valid,
	output ascr_pkg::result_t res
);
	import ascr_pkg::*;

	localparam int AW = COLUMN_BITS + ROW_BITS;
	localparam int PW = $bits(pixel_t);

	back_state_t state_q, state_d;
	logic [AW-1:0] clr_q;
	entry_t        cur_q;
	pixel_t        old_q;
	logic [17:0]   rinc_q, ginc_q, binc_q;
	logic [17:0]   tnew_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	pixel_t        wdata, rpix, upd;
	logic [PW-1:0] rdata;
	logic          res_valid_d;
	result_t       res_d;

	ascr_ram #(.WIDTH(PW), .DEPTH_BITS(AW)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rpix = pixel_t'(rdata);
	assign busy = (state_q != B_IDLE);

	always_comb begin
		upd.red    = sat_add(old_q.red, 32'(rinc_q));
		upd.green  = sat_add(old_q.green, 32'(ginc_q));
		upd.blue   = sat_add(old_q.blue, 32'(binc_q));
		upd.weight = sat_add(old_q.weight, 32'(cur_q.alpha));
		upd.trans  = tnew_q[16:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			res_valid <= res_valid_d;
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		res <= res_d;
		if (pop) begin
			cur_q <= head;
		end
		if (state_q == B_READ) begin
			old_q  <= rpix;
			rinc_q <= 18'((34'(cur_q.red) * 34'(cur_q.alpha)) >> 16);
			ginc_q <= 18'((34'(cur_q.green) * 34'(cur_q.alpha)) >> 16);
			binc_q <= 18'((34'(cur_q.blue) * 34'(cur_q.alpha)) >> 16);
			tnew_q <= 18'((34'(rpix.trans) * 34'(ONE_Q16 - cur_q.alpha)) >> 16);
		end
	end

	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		we          = 1'b0;
		waddr       = cur_q.addr[AW-1:0];
		wdata       = upd;
		raddr       = head.addr[AW-1:0];
		res_valid_d = 1'b0;
		res_d       = '{ST_DROP, 16'd0, pixel_t'('0)};
		unique case (state_q)
			B_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = PIXEL_RESET;
				if (clr_q == '1) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					unique case (head.kind)
						CMD_DROP: begin
							res_valid_d = 1'b1;
						end
						CMD_CLEAR: begin
							we          = 1'b1;
							waddr       = head.addr[AW-1:0];
							wdata       = PIXEL_RESET;
							res_valid_d = 1'b1;
							res_d       = '{ST_CLEAR, head.addr[15:0], PIXEL_RESET};
						end
						default: state_d = B_READ;
					endcase
				end
			end
			B_READ: begin
				if (cur_q.kind == CMD_READ) begin
					res_valid_d = 1'b1;
					res_d       = '{ST_READ, cur_q.addr[15:0], rpix};
					state_d     = B_IDLE;
				end else begin
					state_d = B_WRITE;
				end
			end
			B_WRITE: begin
				we          = 1'b1;
				res_valid_d = 1'b1;
				res_d       = '{ST_ACCUM, cur_q.addr[15:0], upd};
				state_d     = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end
endmodule

/* sv/alpha_weighted_scatter_raster.sv */
// Top level of the alpha-weighted scatter raster.
// Add point: the request passes the mapping front end (difference, multiply, sum, bin, address
// and push states), the queue, the back end (read, write) and the result register. Read and
// clear skip the mapping states. One request is in flight at a time, so a new request is taken
// at the end of the result cycle. After reset all 2^(COLUMN_BITS+ROW_BITS) pixels are cleared,
// one pixel a cycle, with busy high; results are one-cycle strobes the receiver cannot stall.
`timescale 1ns / 1ps
module alpha_weighted_scatter_raster #(
	parameter int COLUMN_BITS = 8,
	parameter int ROW_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	input  logic [16:0]        red,
	input  logic [16:0]        green,
	input  logic [16:0]        blue,
	input  logic [16:0]        alpha,
	input  logic [15:0]        target_pixel,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               result_valid,
	output logic [1:0]         status,
	output logic [15:0]        pixel_address,
	output logic [31:0]        red_sum,
	output logic [31:0]        green_sum,
	output logic [31:0]        blue_sum,
	output logic [31:0]        weight_sum,
	output logic [16:0]        transparency
);
	import ascr_pkg::*;

	logic    front_busy, back_busy, push, pop, empty, full, accept;
	entry_t  push_entry, head;
	result_t res;

	assign cfg_ready = 1'b1;
	assign busy      = front_busy || back_busy || !empty;
	assign accept    = start && !busy;

	ascr_front #(.COLUMN_BITS(COLUMN_BITS), .ROW_BITS(ROW_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.op          (op),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.alpha       (alpha),
		.target_pixel(target_pixel),
		.cfg_write   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.full        (full),
		.push        (push),
		.push_entry  (push_entry),
		.busy        (front_busy)
	);

	ascr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	ascr_back #(.COLUMN_BITS(COLUMN_BITS), .ROW_BITS(ROW_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.busy     (back_busy),
		.res_valid(result_valid),
		.res      (res)
	);

	assign status        = res.status;
	assign pixel_address = res.addr;
	assign red_sum       = res.px.red;
	assign green_sum     = res.px.green;
	assign blue_sum      = res.px.blue;
	assign weight_sum    = res.px.weight;
	assign transparency  = res.px.trans;
endmodule

/* sv/ascr_checker.sv */
// Port-level checks of the alpha-weighted scatter raster and their binding.
`timescale 1ns / 1ps
module ascr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        result_valid,
	input logic [1:0]  status,
	input logic [15:0] pixel_address,
	input logic [31:0] red_sum,
	input logic [31:0] weight_sum,
	input logic [16:0] transparency
);
	import ascr_pkg::*;

	// A taken request keeps the block busy until its result is out.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy did not rise after a request");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("two results in a row");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_DROP |-> pixel_address == 16'd0
		&& red_sum == 32'd0 && weight_sum == 32'd0 && transparency == 17'd0)
		else $error("dropped point carries data");

	a_clear_values: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_CLEAR |-> transparency == ONE_Q16
		&& weight_sum == 32'd0 && red_sum == 32'd0)
		else $error("cleared pixel does not hold reset values");

	a_trans_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> transparency <= ONE_Q16)
		else $error("transparency above one");
endmodule

bind alpha_weighted_scatter_raster ascr_checker u_ascr_checker (.*);
